@@ rtl/trht_pkg.sv @@
package trht_pkg;

   localparam int MAX_REGIONS = 30;
   localparam int COORD_W     = 12;
   localparam int TAG_W       = 8;
   localparam int YF_W        = 16;
   localparam int STATUS_W    = 3;
   localparam int HIT_INDEX_W = 5;
   localparam int OP_W        = 2;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int MEM_AW      = IDX_W + 1;
   localparam int MEM_DEPTH   = 2 ** MEM_AW;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_TOUCH = 2'd2;

   localparam logic CSR_SEL_OVERLAY = 1'b0;
   localparam logic CSR_SEL_HEIGHT  = 1'b1;

   localparam logic [COORD_W-1:0] HEIGHT_RESET = COORD_W'(540);
   localparam logic [CNT_W-1:0]   CNT_FULL     = CNT_W'(MAX_REGIONS);

   typedef enum logic [STATUS_W-1:0] {
      STAT_HIT     = 3'd0,
      STAT_NO_HIT  = 3'd1,
      STAT_ADDED   = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_CLEARED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WRITE,
      S_SCAN,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [TAG_W-1:0]   tag;
   } region_type;

endpackage

@@ rtl/touch_region_hit_test.sv @@
// Channel   Dir  Handshake            Payload
// req       in   req_valid/req_ready  opcode, table_select, region rect, tag, touch x/y
// rsp       out  rsp_valid/rsp_ready  status, hit_handler, hit_index, last
// csr       in   APB, pready tied 1   0x0 overlay_active, 0x4 screen_height
//
// Add and clear: S_WRITE registers the result once rsp is free; add does one region RAM write unless full.
// Touch: S_SCAN reads each region of the active table, then S_FINAL gives the last result.
// The single RAM read port scans one region per cycle while a stalled rsp does not hold the scan.
// Synchronous active-high reset clears state, counts and valid flags and sets height to 540; region RAM is not cleared.
// A stalled rsp holds the scan once a second hit is found; req is ready only in idle.
module touch_region_hit_test (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [trht_pkg::OP_W-1:0]           req_opcode,
   input  logic                                req_table_select,
   input  logic [trht_pkg::COORD_W-1:0]        req_region_left,
   input  logic [trht_pkg::COORD_W-1:0]        req_region_top,
   input  logic [trht_pkg::COORD_W-1:0]        req_region_width,
   input  logic [trht_pkg::COORD_W-1:0]        req_region_height,
   input  logic [trht_pkg::TAG_W-1:0]          req_handler_tag,
   input  logic [trht_pkg::COORD_W-1:0]        req_touch_x,
   input  logic [trht_pkg::COORD_W-1:0]        req_touch_y,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [trht_pkg::STATUS_W-1:0]       rsp_status,
   output logic [trht_pkg::TAG_W-1:0]          rsp_hit_handler,
   output logic [trht_pkg::HIT_INDEX_W-1:0]    rsp_hit_index,
   output logic                                rsp_last,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [trht_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [trht_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [trht_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   trht_pkg::state_type state_ff, state_in;

   logic                                overlay_ff, overlay_in;
   logic [trht_pkg::COORD_W-1:0]        height_ff, height_in;
   logic [trht_pkg::CNT_W-1:0]          norm_cnt_ff, norm_cnt_in;
   logic [trht_pkg::CNT_W-1:0]          ovl_cnt_ff, ovl_cnt_in;

   logic [trht_pkg::OP_W-1:0]           op_ff, op_in;
   logic                                sel_ff, sel_in;
   trht_pkg::region_type                new_ff, new_in;
   logic [trht_pkg::COORD_W-1:0]        x_ff, x_in;
   logic [trht_pkg::YF_W-1:0]           yf_ff, yf_in;

   logic                                scan_tab_ff, scan_tab_in;
   logic [trht_pkg::CNT_W-1:0]          scan_n_ff, scan_n_in;
   logic [trht_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic                                s1_valid_ff, s1_valid_in;
   logic [trht_pkg::IDX_W-1:0]          s1_idx_ff, s1_idx_in;
   trht_pkg::region_type                rd_data_ff;

   logic                                pend_valid_ff, pend_valid_in;
   logic [trht_pkg::TAG_W-1:0]          pend_tag_ff, pend_tag_in;
   logic [trht_pkg::IDX_W-1:0]          pend_idx_ff, pend_idx_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   trht_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [trht_pkg::TAG_W-1:0]          rsp_tag_ff, rsp_tag_in;
   logic [trht_pkg::HIT_INDEX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                                rsp_last_ff, rsp_last_in;

   trht_pkg::region_type                mem [trht_pkg::MEM_DEPTH];

   logic                                accept;
   logic                                out_free;
   logic                                issue;
   logic                                match;
   logic                                hit;
   logic                                adv;
   logic                                rd_en;
   logic                                mem_we;
   logic                                done_write;
   logic                                done_final;
   logic                                full;
   logic [trht_pkg::CNT_W-1:0]          sel_cnt;
   logic [trht_pkg::MEM_AW-1:0]         wr_addr;
   logic [trht_pkg::MEM_AW-1:0]         rd_addr;
   logic                                csr_wr;

   trht_match u_match (
      .region (rd_data_ff),
      .x      (x_ff),
      .yf     (yf_ff),
      .hit    (match)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == trht_pkg::CSR_SEL_HEIGHT) ?
                       trht_pkg::CSR_DW'(height_ff) : trht_pkg::CSR_DW'(overlay_ff);

   always_comb begin
      overlay_in = overlay_ff;
      height_in  = height_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            trht_pkg::CSR_SEL_OVERLAY: overlay_in = csr_pwdata[0];
            trht_pkg::CSR_SEL_HEIGHT:  height_in  = csr_pwdata[trht_pkg::COORD_W-1:0];
            default:                   overlay_in = overlay_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trht_pkg::S_IDLE: begin
            if (req_valid) begin
               priority if (req_opcode == trht_pkg::OP_ADD || req_opcode == trht_pkg::OP_CLEAR)
                  state_in = trht_pkg::S_WRITE;
               else if (req_opcode == trht_pkg::OP_TOUCH)
                  state_in = trht_pkg::S_SCAN;
               else
                  state_in = trht_pkg::S_IDLE;
            end
         end
         trht_pkg::S_WRITE: begin
            if (out_free) state_in = trht_pkg::S_IDLE;
         end
         trht_pkg::S_SCAN: begin
            if (!issue && !s1_valid_ff) state_in = trht_pkg::S_FINAL;
         end
         trht_pkg::S_FINAL: begin
            if (out_free) state_in = trht_pkg::S_IDLE;
         end
         default: state_in = trht_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = (state_ff == trht_pkg::S_IDLE);
      accept     = req_valid && req_ready;
      out_free   = !rsp_valid_ff || rsp_ready;
      issue      = (state_ff == trht_pkg::S_SCAN) && (idx_ff < scan_n_ff);
      hit        = s1_valid_ff && match;
      adv        = !(hit && pend_valid_ff && !out_free);
      rd_en      = adv && issue;
      sel_cnt    = sel_ff ? ovl_cnt_ff : norm_cnt_ff;
      full       = (sel_cnt >= trht_pkg::CNT_FULL);
      done_write = (state_ff == trht_pkg::S_WRITE) && out_free;
      done_final = (state_ff == trht_pkg::S_FINAL) && out_free;
      mem_we     = done_write && (op_ff == trht_pkg::OP_ADD) && !full;
      wr_addr    = {sel_ff, sel_cnt[trht_pkg::IDX_W-1:0]};
      rd_addr    = {scan_tab_ff, idx_ff[trht_pkg::IDX_W-1:0]};
   end

   // datapath next values
   always_comb begin
      op_in       = op_ff;
      sel_in      = sel_ff;
      new_in      = new_ff;
      x_in        = x_ff;
      yf_in       = yf_ff;
      scan_tab_in = scan_tab_ff;
      scan_n_in   = scan_n_ff;
      idx_in      = idx_ff;
      norm_cnt_in = norm_cnt_ff;
      ovl_cnt_in  = ovl_cnt_ff;
      s1_valid_in = adv ? issue : s1_valid_ff;
      s1_idx_in   = rd_en ? idx_ff[trht_pkg::IDX_W-1:0] : s1_idx_ff;

      pend_valid_in = pend_valid_ff;
      pend_tag_in   = pend_tag_ff;
      pend_idx_in   = pend_idx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         op_in       = req_opcode;
         sel_in      = req_table_select;
         new_in      = '{left:   req_region_left,
                         top:    req_region_top,
                         width:  req_region_width,
                         height: req_region_height,
                         tag:    req_handler_tag};
         x_in        = req_touch_x;
         yf_in       = trht_pkg::YF_W'(height_ff) - trht_pkg::YF_W'(req_touch_y);
         scan_tab_in = overlay_ff;
         scan_n_in   = overlay_ff ? ovl_cnt_ff : norm_cnt_ff;
         idx_in      = '0;
      end

      if (rd_en) idx_in = idx_ff + 1'b1;

      if (done_write) begin
         rsp_valid_in = 1'b1;
         rsp_tag_in   = '0;
         rsp_idx_in   = '0;
         rsp_last_in  = 1'b1;
         if (op_ff == trht_pkg::OP_CLEAR) begin
            rsp_status_in = trht_pkg::STAT_CLEARED;
            if (sel_ff) ovl_cnt_in = '0;
            else        norm_cnt_in = '0;
         end else if (full) begin
            rsp_status_in = trht_pkg::STAT_FULL;
         end else begin
            rsp_status_in = trht_pkg::STAT_ADDED;
            if (sel_ff) ovl_cnt_in = ovl_cnt_ff + 1'b1;
            else        norm_cnt_in = norm_cnt_ff + 1'b1;
         end
      end

      // a found hit is held until the next one shows it was not the last
      if (hit && adv) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = trht_pkg::STAT_HIT;
            rsp_tag_in    = pend_tag_ff;
            rsp_idx_in    = trht_pkg::HIT_INDEX_W'(pend_idx_ff);
            rsp_last_in   = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_tag_in   = rd_data_ff.tag;
         pend_idx_in   = s1_idx_ff;
      end

      if (done_final) begin
         rsp_valid_in  = 1'b1;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_status_in = trht_pkg::STAT_HIT;
            rsp_tag_in    = pend_tag_ff;
            rsp_idx_in    = trht_pkg::HIT_INDEX_W'(pend_idx_ff);
         end else begin
            rsp_status_in = trht_pkg::STAT_NO_HIT;
            rsp_tag_in    = '0;
            rsp_idx_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= new_ff;
      if (rd_en)  rd_data_ff   <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trht_pkg::S_IDLE;
         overlay_ff    <= 1'b0;
         height_ff     <= trht_pkg::HEIGHT_RESET;
         norm_cnt_ff   <= '0;
         ovl_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         overlay_ff    <= overlay_in;
         height_ff     <= height_in;
         norm_cnt_ff   <= norm_cnt_in;
         ovl_cnt_ff    <= ovl_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      new_ff        <= new_in;
      x_ff          <= x_in;
      yf_ff         <= yf_in;
      scan_tab_ff   <= scan_tab_in;
      scan_n_ff     <= scan_n_in;
      idx_ff        <= idx_in;
      s1_idx_ff     <= s1_idx_in;
      pend_tag_ff   <= pend_tag_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit_handler = rsp_tag_ff;
   assign rsp_hit_index   = rsp_idx_ff;
   assign rsp_last        = rsp_last_ff;

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == trht_pkg::S_SCAN || state_ff == trht_pkg::S_FINAL))
      else $error("pending hit outside scan");

   a_s1_in_scan: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == trht_pkg::S_SCAN))
      else $error("read stage valid outside scan");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (norm_cnt_ff <= trht_pkg::CNT_FULL) && (ovl_cnt_ff <= trht_pkg::CNT_FULL))
      else $error("region count above table size");

   a_write_last: assert property (@(posedge clock) disable iff (reset)
      done_write |=> (rsp_valid_ff && rsp_last_ff))
      else $error("add or clear result missing or not last");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_idx_ff) && $stable(idx_ff)))
      else $error("scan advanced while output stalled");

endmodule

@@ rtl/trht_match.sv @@
module trht_match (
   input  trht_pkg::region_type           region,
   input  logic [trht_pkg::COORD_W-1:0]   x,
   input  logic [trht_pkg::YF_W-1:0]      yf,
   output logic                           hit
);

   logic [trht_pkg::COORD_W:0] right;
   logic [trht_pkg::COORD_W:0] bottom;
   logic                       in_x;
   logic                       in_y;

   assign right  = {1'b0, region.left} + {1'b0, region.width};
   assign bottom = {1'b0, region.top} + {1'b0, region.height};

   assign in_x = (x > region.left) && ({1'b0, x} < right);
   assign in_y = (yf > trht_pkg::YF_W'(region.top)) && (yf < trht_pkg::YF_W'(bottom));
   assign hit  = in_x && in_y;

endmodule

@@ tb/touch_region_hit_checker.sv @@
`timescale 1ns / 100ps
module touch_region_hit_checker
   import trht_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [OP_W-1:0]        req_opcode,
   input  logic                   req_table_select,
   input  logic [COORD_W-1:0]     req_region_left,
   input  logic [COORD_W-1:0]     req_region_top,
   input  logic [COORD_W-1:0]     req_region_width,
   input  logic [COORD_W-1:0]     req_region_height,
   input  logic [TAG_W-1:0]       req_handler_tag,
   input  logic [COORD_W-1:0]     req_touch_x,
   input  logic [COORD_W-1:0]     req_touch_y,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic [TAG_W-1:0]       rsp_hit_handler,
   input  logic [HIT_INDEX_W-1:0] rsp_hit_index,
   input  logic                   rsp_last,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_AW-1:0]      csr_paddr,
   input  logic [CSR_DW-1:0]      csr_pwdata,
   input  logic [CSR_DW-1:0]      csr_prdata,
   input  logic                   csr_pready,

   output int                     error_count,
   output int                     results_pending
);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [TAG_W-1:0]       handler;
      logic [HIT_INDEX_W-1:0] index;
      logic                   last;
   } hit_result_type;

   region_type         region_table [2][MAX_REGIONS];
   int unsigned        region_count [2];
   logic               overlay_sel;
   logic [COORD_W-1:0] height_cfg;
   hit_result_type     expected_hits [$];

   initial begin
      error_count     = 0;
      results_pending = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic hit_result_type make_result(input logic [STATUS_W-1:0] status,
                                                  input logic [TAG_W-1:0] handler,
                                                  input logic [HIT_INDEX_W-1:0] index,
                                                  input logic last);
      hit_result_type res;
      res.status  = status;
      res.handler = handler;
      res.index   = index;
      res.last    = last;
      return res;
   endfunction

   // Work out every result one accepted transfer causes and queue them.
   function automatic void predict_hits(input logic [OP_W-1:0] op, input logic sel,
                                        input region_type add_rect,
                                        input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y);
      logic [YF_W-1:0] yf;
      logic            tbl;
      logic            have_hit;
      hit_result_type  held_hit;
      region_type      r;
      int              xi, yi, i;
      case (op)
         OP_ADD: begin
            if (region_count[sel] >= MAX_REGIONS) begin
               expected_hits.push_back(make_result(STAT_FULL, '0, '0, 1'b1));
            end else begin
               region_table[sel][region_count[sel]] = add_rect;
               region_count[sel]++;
               expected_hits.push_back(make_result(STAT_ADDED, '0, '0, 1'b1));
            end
         end
         OP_CLEAR: begin
            region_count[sel] = 0;
            expected_hits.push_back(make_result(STAT_CLEARED, '0, '0, 1'b1));
         end
         OP_TOUCH: begin
            tbl      = overlay_sel;
            yf       = YF_W'(height_cfg) - YF_W'(y);
            xi       = int'(x);
            yi       = int'(yf);
            have_hit = 1'b0;
            held_hit = '0;
            for (i = 0; i < region_count[tbl]; i++) begin
               r = region_table[tbl][i];
               if (xi > int'(r.left) && xi < int'(r.left) + int'(r.width) &&
                   yi > int'(r.top) && yi < int'(r.top) + int'(r.height)) begin
                  if (have_hit) expected_hits.push_back(held_hit);
                  held_hit = make_result(STAT_HIT, r.tag, HIT_INDEX_W'(i), 1'b0);
                  have_hit = 1'b1;
               end
            end
            if (have_hit) begin
               held_hit.last = 1'b1;
               expected_hits.push_back(held_hit);
            end else begin
               expected_hits.push_back(make_result(STAT_NO_HIT, '0, '0, 1'b1));
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      hit_result_type     exp_hit;
      region_type         add_rect;
      logic [CSR_DW-1:0]  exp_word;
      if (reset) begin
         region_count[0] = 0;
         region_count[1] = 0;
         overlay_sel     = 1'b0;
         height_cfg      = HEIGHT_RESET;
         expected_hits.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_SEL_HEIGHT) height_cfg = csr_pwdata[COORD_W-1:0];
               else overlay_sel = csr_pwdata[0];
            end else begin
               exp_word = (csr_paddr[2] == CSR_SEL_HEIGHT) ? CSR_DW'(height_cfg)
                                                           : CSR_DW'(overlay_sel);
               if (csr_prdata !== exp_word)
                  report_mismatch($sformatf("csr read addr %0h got %0h expected %0h",
                                            csr_paddr, csr_prdata, exp_word));
            end
         end

         if (req_valid && req_ready) begin
            add_rect.left   = req_region_left;
            add_rect.top    = req_region_top;
            add_rect.width  = req_region_width;
            add_rect.height = req_region_height;
            add_rect.tag    = req_handler_tag;
            predict_hits(req_opcode, req_table_select, add_rect, req_touch_x, req_touch_y);
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp transfer, status %0d handler %0d",
                                         rsp_status, rsp_hit_handler));
            end else begin
               exp_hit = expected_hits.pop_front();
               if (rsp_status !== exp_hit.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_status, exp_hit.status));
               if (rsp_hit_handler !== exp_hit.handler)
                  report_mismatch($sformatf("hit_handler got %0d expected %0d",
                                            rsp_hit_handler, exp_hit.handler));
               if (rsp_hit_index !== exp_hit.index)
                  report_mismatch($sformatf("hit_index got %0d expected %0d",
                                            rsp_hit_index, exp_hit.index));
               if (rsp_last !== exp_hit.last)
                  report_mismatch($sformatf("last got %0d expected %0d",
                                            rsp_last, exp_hit.last));
            end
         end
      end
      results_pending = expected_hits.size();
   end

endmodule

@@ tb/tb_touch_region_hit_test.sv @@
`timescale 1ns / 100ps
module tb_touch_region_hit_test;
   import trht_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_PCT      = 12;
   localparam int IDLE_LIMIT     = 4000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 42;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam logic [PHASES-1:0] FILL_PHASES    = 8'b0010_0001;
   localparam logic [PHASES-1:0] OVERLAY_PHASES = 8'b1001_0101;
   localparam logic [CSR_AW-1:0] ADDR_OVERLAY   = {CSR_SEL_OVERLAY, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_HEIGHT    = {CSR_SEL_HEIGHT, 2'b00};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [OP_W-1:0]        req_opcode = OP_ADD;
   logic                   req_table_select = 1'b0;
   logic [COORD_W-1:0]     req_region_left = '0;
   logic [COORD_W-1:0]     req_region_top = '0;
   logic [COORD_W-1:0]     req_region_width = '0;
   logic [COORD_W-1:0]     req_region_height = '0;
   logic [TAG_W-1:0]       req_handler_tag = '0;
   logic [COORD_W-1:0]     req_touch_x = '0;
   logic [COORD_W-1:0]     req_touch_y = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [TAG_W-1:0]       rsp_hit_handler;
   logic [HIT_INDEX_W-1:0] rsp_hit_index;
   logic                   rsp_last;

   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   int                     error_count;
   int                     results_pending;
   int                     idle_cycles = 0;
   bit                     steady = 1'b0;
   logic                   cur_overlay = 1'b0;
   logic [COORD_W-1:0]     cur_height = HEIGHT_RESET;
   region_type             aim_pool [2][MAX_REGIONS];
   int                     aim_count [2];

   touch_region_hit_test DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_table_select  (req_table_select),
      .req_region_left   (req_region_left),
      .req_region_top    (req_region_top),
      .req_region_width  (req_region_width),
      .req_region_height (req_region_height),
      .req_handler_tag   (req_handler_tag),
      .req_touch_x       (req_touch_x),
      .req_touch_y       (req_touch_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_hit_handler   (rsp_hit_handler),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   touch_region_hit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_table_select  (req_table_select),
      .req_region_left   (req_region_left),
      .req_region_top    (req_region_top),
      .req_region_width  (req_region_width),
      .req_region_height (req_region_height),
      .req_handler_tag   (req_handler_tag),
      .req_touch_x       (req_touch_x),
      .req_touch_y       (req_touch_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_hit_handler   (rsp_hit_handler),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready),
      .error_count       (error_count),
      .results_pending   (results_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic region_type make_region(input int l, input int t, input int w,
                                              input int h, input int tag);
      region_type r;
      r.left   = COORD_W'(l);
      r.top    = COORD_W'(t);
      r.width  = COORD_W'(w);
      r.height = COORD_W'(h);
      r.tag    = TAG_W'(tag);
      return r;
   endfunction

   // big regions cover nearly the whole screen so touches stack many hits
   function automatic region_type random_region(input bit big);
      if (big)
         return make_region($urandom_range(60, 0), $urandom_range(60, 0),
                            $urandom_range(COORD_MAX, 3900), $urandom_range(COORD_MAX, 3900),
                            $urandom);
      if ($urandom_range(3) == 0)
         return make_region($urandom, $urandom, $urandom, $urandom, $urandom);
      return make_region($urandom_range(3500, 0), $urandom_range(3500, 0),
                         $urandom_range(1200, 0), $urandom_range(1200, 0), $urandom);
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic sel, input region_type r,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      @(negedge clock);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_table_select  <= sel;
      req_region_left   <= r.left;
      req_region_top    <= r.top;
      req_region_width  <= r.width;
      req_region_height <= r.height;
      req_handler_tag   <= r.tag;
      req_touch_x       <= x;
      req_touch_y       <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_ADD && aim_count[sel] < MAX_REGIONS) begin
         aim_pool[sel][aim_count[sel]] = r;
         aim_count[sel]++;
      end else if (op == OP_CLEAR) begin
         aim_count[sel] = 0;
      end
   endtask

   // Mostly aim inside a region added to the active table since its last clear.
   task automatic aim_touch(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
      region_type r;
      int         tx, ty;
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      if (aim_count[cur_overlay] > 0 && $urandom_range(9) < 7) begin
         r  = aim_pool[cur_overlay][$urandom_range(aim_count[cur_overlay] - 1)];
         tx = r.left + 1 + ((r.width > 2) ? $urandom_range(r.width - 2) : 0);
         ty = r.top + 1 + ((r.height > 2) ? $urandom_range(r.height - 2) : 0);
         if (tx <= COORD_MAX) x = COORD_W'(tx);
         if (ty <= cur_height) y = COORD_W'(int'(cur_height) - ty);
      end
   endtask

   task automatic send_random(input bit fill);
      int                 pick;
      logic [OP_W-1:0]    op;
      logic               sel;
      logic [COORD_W-1:0] x, y;
      pick = $urandom_range(99);
      sel  = fill ? cur_overlay : 1'($urandom_range(1));
      x    = COORD_W'($urandom);
      y    = COORD_W'($urandom);
      if (fill) op = (pick < 70) ? OP_ADD : OP_TOUCH;
      else if (pick < 40) op = OP_ADD;
      else if (pick < 85) op = OP_TOUCH;
      else if (pick < 93) op = OP_CLEAR;
      else op = OP_UNUSED;
      if (op == OP_TOUCH) aim_touch(x, y);
      send_item(op, sel, random_region(fill), x, y);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic ovl, input logic [COORD_W-1:0] hgt);
      wait_idle();
      csr_access(1'b1, ADDR_OVERLAY, CSR_DW'(ovl));
      csr_access(1'b1, ADDR_HEIGHT, CSR_DW'(hgt));
      csr_access(1'b0, ADDR_OVERLAY, '0);
      csr_access(1'b0, ADDR_HEIGHT, '0);
      cur_overlay = ovl;
      cur_height  = hgt;
   endtask

   initial begin : stimulus
      logic [COORD_W-1:0] hgt;
      int                 phase;
      aim_count[0] = 0;
      aim_count[1] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edges, strict containment, y wrap, stale entries after clear
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 0, 0);
      send_item(OP_UNUSED, 1'b1, make_region(4095, 4095, 4095, 4095, 255), 4095, 4095);
      send_item(OP_ADD, 1'b0, make_region(0, 0, 4095, 4095, 8'hff), 0, 0);
      send_item(OP_ADD, 1'b0, make_region(4095, 4095, 4095, 4095, 8'h00), 4095, 4095);
      send_item(OP_ADD, 1'b0, make_region(100, 100, 200, 200, 8'ha5), 0, 0);
      send_item(OP_ADD, 1'b1, make_region(10, 10, 20, 20, 8'h5a), 0, 0);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 150, 390);
      send_item(OP_TOUCH, 1'b1, make_region(0, 0, 0, 0, 0), 0, 390);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 4095, 0);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 4094, 4095);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 1, 539);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 100, 390);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 299, 241);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 300, 240);
      send_item(OP_CLEAR, 1'b0, make_region(0, 0, 0, 0, 0), 0, 0);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 150, 390);
      send_item(OP_ADD, 1'b0, make_region(0, 0, 2, 2, 8'h01), 0, 0);
      send_item(OP_TOUCH, 1'b0, make_region(0, 0, 0, 0, 0), 1, 539);
      send_item(OP_CLEAR, 1'b1, make_region(0, 0, 0, 0, 0), 0, 0);
      send_item(OP_ADD, 1'b1, make_region(0, 0, 4095, 4095, 8'h80), 0, 0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0, 5:    hgt = COORD_W'(COORD_MAX);
            1:       hgt = '0;
            2, 6:    hgt = HEIGHT_RESET;
            default: hgt = COORD_W'($urandom_range(COORD_MAX));
         endcase
         set_config(OVERLAY_PHASES[phase], hgt);
         steady = (phase == 3);
         repeat (PHASE_ITEMS) send_random(FILL_PHASES[phase]);
      end
      steady = 1'b0;

      wait_idle();
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
